@@ hdl/mcar_pkg.sv @@
// ----------------------------------------------------------------------------
// mcar_pkg
// Shared types, constants and helper functions of the modulated comb and
// allpass reverb: command codes, saturation and the sine table.
// ----------------------------------------------------------------------------
package mcar_pkg;

   // Structure of the reverb network.
   localparam int NUM_COMBS = 4;
   localparam int NUM_AP    = 3;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_FEEDBACK  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIFFUSION = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WET       = 2'd2;

   localparam logic [14:0] FEEDBACK_RESET  = 15'd26214;
   localparam logic [14:0] DIFFUSION_RESET = 15'd16384;
   localparam logic [15:0] WET_RESET       = 16'd9830;
   localparam logic [15:0] WET_ONE         = 16'd32768;

   // Fixed-point constants: damping 0.3 in Q15, modulation depth 0.003 in Q24.
   localparam logic signed [15:0] DAMP_K = 16'sd9830;
   localparam int MOD_K = 50332;

   // Width used when handing a wide intermediate to the saturator.
   localparam int SAT_W = 40;

   // Datapath command codes.
   localparam int OP_W = 5;
   localparam logic [OP_W-1:0] OP_NONE   = 5'd0;
   localparam logic [OP_W-1:0] OP_LOAD   = 5'd1;
   localparam logic [OP_W-1:0] OP_PHASE  = 5'd2;
   localparam logic [OP_W-1:0] OP_MAG    = 5'd3;
   localparam logic [OP_W-1:0] OP_RPOS   = 5'd4;
   localparam logic [OP_W-1:0] OP_RD1    = 5'd5;
   localparam logic [OP_W-1:0] OP_RD2    = 5'd6;
   localparam logic [OP_W-1:0] OP_INTERP = 5'd7;
   localparam logic [OP_W-1:0] OP_DAMP1  = 5'd8;
   localparam logic [OP_W-1:0] OP_DAMP2  = 5'd9;
   localparam logic [OP_W-1:0] OP_FBWR   = 5'd10;
   localparam logic [OP_W-1:0] OP_SUM    = 5'd11;
   localparam logic [OP_W-1:0] OP_APRD   = 5'd12;
   localparam logic [OP_W-1:0] OP_APMUL  = 5'd13;
   localparam logic [OP_W-1:0] OP_APWR   = 5'd14;
   localparam logic [OP_W-1:0] OP_MIX1   = 5'd15;
   localparam logic [OP_W-1:0] OP_MIX2   = 5'd16;
   localparam logic [OP_W-1:0] OP_OUT    = 5'd17;

   // Command from the controller to the datapath.
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [1:0]      comb;
      logic [1:0]      stage;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_busy;
   } status_type;

   // Clamp a wide signed value to signed 16 bits.
   function automatic logic signed [15:0] sat16(input logic signed [SAT_W-1:0] x);
      if (x > 40'sd32767) begin
         return 16'sh7FFF;
      end else if (x < -40'sd32768) begin
         return 16'sh8000;
      end else begin
         return x[15:0];
      end
   endfunction

   // Sine table: quarter-wave odd polynomial in Q30, evaluated at elaboration.
   localparam int SineEntries = 256;
   localparam int SINE_BITS   = 8;
   localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
   localparam logic [63:0] C1 = 64'd1686629713;
   localparam logic [63:0] C3 = 64'd693598668;
   localparam logic [63:0] C5 = 64'd85569305;
   localparam logic [63:0] C7 = 64'd5026996;
   localparam logic [63:0] C9 = 64'd172272;

   typedef logic signed [15:0] sine_tab_type [SineEntries];

   function automatic logic signed [15:0] sine_entry(input int k);
      logic [63:0] t;
      logic [63:0] q;
      logic [63:0] u;
      logic [63:0] u2;
      logic [63:0] p;
      logic [63:0] s;
      logic [63:0] v;
      t = 64'(k) * 64'd4;
      // Quadrant and position inside it; the table size is a power of two.
      q = (t >> SINE_BITS) & 64'd3;
      u = (t & 64'(SineEntries - 1)) << (30 - SINE_BITS);
      if (q[0]) begin
         u = ONE_Q30 - u;
      end
      u2 = (u * u) >> 30;
      p = C7 - ((u2 * C9) >> 30);
      p = C5 - ((u2 * p) >> 30);
      p = C3 - ((u2 * p) >> 30);
      p = C1 - ((u2 * p) >> 30);
      s = (u * p) >> 30;
      v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return q[1] ? -$signed(v[15:0]) : $signed(v[15:0]);
   endfunction

   function automatic sine_tab_type build_sine();
      sine_tab_type tab;
      for (int k = 0; k < SineEntries; k++) begin
         tab[k] = sine_entry(k);
      end
      return tab;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine();

endpackage

@@ hdl/modulated_comb_allpass_reverb.sv @@
// ----------------------------------------------------------------------------
// modulated_comb_allpass_reverb
// Four LFO-modulated comb lines with damping, three allpass stages and a
// dry/wet mix, one audio sample per request.
// ----------------------------------------------------------------------------
// The shared datapath spends nine steps per comb, one on the comb sum, three
// per allpass stage and three on the mix and handoff, after the idle state in
// which the request is taken; the handoff step waits while the result before
// it still stalls downstream.
// A new request is taken while the previous result still waits downstream.
// Reset is synchronous; line memories need no clearing pass, since fill flags
// make never-written entries read as zero.
module modulated_comb_allpass_reverb #(
   parameter int SAMPLE_RATE   = 48000,
   parameter int COMB_DEPTH    = 4096,
   parameter int ALLPASS_DEPTH = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [15:0]                  req_sample_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [15:0]                  rsp_sample_out,
   input  logic                                csr_write,
   input  logic [mcar_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mcar_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import mcar_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   mcar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Arithmetic, state and line memories.
   mcar_dpath #(
      .SAMPLE_RATE   (SAMPLE_RATE),
      .COMB_DEPTH    (COMB_DEPTH),
      .ALLPASS_DEPTH (ALLPASS_DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

endmodule

@@ hdl/mcar_ctrl.sv @@
// ----------------------------------------------------------------------------
// mcar_ctrl
// Sequencer of the reverb: steps the shared datapath through the four combs,
// the three allpass stages, the dry/wet mix and the result handoff.
// ----------------------------------------------------------------------------
module mcar_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output mcar_pkg::cmd_type    cmd,
   input  mcar_pkg::status_type status
);
   import mcar_pkg::*;

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_PHASE  = 5'd1;
   localparam logic [4:0] S_MAG    = 5'd2;
   localparam logic [4:0] S_RPOS   = 5'd3;
   localparam logic [4:0] S_RD1    = 5'd4;
   localparam logic [4:0] S_RD2    = 5'd5;
   localparam logic [4:0] S_INTERP = 5'd6;
   localparam logic [4:0] S_DAMP1  = 5'd7;
   localparam logic [4:0] S_DAMP2  = 5'd8;
   localparam logic [4:0] S_FBWR   = 5'd9;
   localparam logic [4:0] S_SUM    = 5'd10;
   localparam logic [4:0] S_APRD   = 5'd11;
   localparam logic [4:0] S_APMUL  = 5'd12;
   localparam logic [4:0] S_APWR   = 5'd13;
   localparam logic [4:0] S_MIX1   = 5'd14;
   localparam logic [4:0] S_MIX2   = 5'd15;
   localparam logic [4:0] S_OUT    = 5'd16;

   localparam logic [1:0] LAST_COMB  = 2'(NUM_COMBS - 1);
   localparam logic [1:0] LAST_STAGE = 2'(NUM_AP - 1);

   logic [4:0] state_ff, state_in;
   logic [1:0] comb_ff, comb_in;
   logic [1:0] stage_ff, stage_in;

   // Only the idle state takes a new request.
   assign req_stall = (state_ff != S_IDLE);

   // Next state and loop counters.
   always_comb begin
      state_in = state_ff;
      comb_in  = comb_ff;
      stage_in = stage_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_PHASE;
               comb_in  = 2'd0;
            end
         end
         S_PHASE:  state_in = S_MAG;
         S_MAG:    state_in = S_RPOS;
         S_RPOS:   state_in = S_RD1;
         S_RD1:    state_in = S_RD2;
         S_RD2:    state_in = S_INTERP;
         S_INTERP: state_in = S_DAMP1;
         S_DAMP1:  state_in = S_DAMP2;
         S_DAMP2:  state_in = S_FBWR;
         S_FBWR: begin
            if (comb_ff == LAST_COMB) begin
               state_in = S_SUM;
            end else begin
               state_in = S_PHASE;
               comb_in  = comb_ff + 2'd1;
            end
         end
         S_SUM: begin
            state_in = S_APRD;
            stage_in = 2'd0;
         end
         S_APRD:  state_in = S_APMUL;
         S_APMUL: state_in = S_APWR;
         S_APWR: begin
            if (stage_ff == LAST_STAGE) begin
               state_in = S_MIX1;
            end else begin
               state_in = S_APRD;
               stage_in = stage_ff + 2'd1;
            end
         end
         S_MIX1: state_in = S_MIX2;
         S_MIX2: state_in = S_OUT;
         S_OUT: begin
            if (!status.out_busy) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Command decode.
   always_comb begin
      cmd.comb  = comb_ff;
      cmd.stage = stage_ff;
      unique case (state_ff)
         S_IDLE:   cmd.op = req_valid ? OP_LOAD : OP_NONE;
         S_PHASE:  cmd.op = OP_PHASE;
         S_MAG:    cmd.op = OP_MAG;
         S_RPOS:   cmd.op = OP_RPOS;
         S_RD1:    cmd.op = OP_RD1;
         S_RD2:    cmd.op = OP_RD2;
         S_INTERP: cmd.op = OP_INTERP;
         S_DAMP1:  cmd.op = OP_DAMP1;
         S_DAMP2:  cmd.op = OP_DAMP2;
         S_FBWR:   cmd.op = OP_FBWR;
         S_SUM:    cmd.op = OP_SUM;
         S_APRD:   cmd.op = OP_APRD;
         S_APMUL:  cmd.op = OP_APMUL;
         S_APWR:   cmd.op = OP_APWR;
         S_MIX1:   cmd.op = OP_MIX1;
         S_MIX2:   cmd.op = OP_MIX2;
         S_OUT:    cmd.op = status.out_busy ? OP_NONE : OP_OUT;
         default:  cmd.op = OP_NONE;
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         comb_ff  <= 2'd0;
         stage_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         comb_ff  <= comb_in;
         stage_ff <= stage_in;
      end
   end

   // A comb that is not the last one hands over to the next comb.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FBWR && comb_ff != LAST_COMB)
         |=> (state_ff == S_PHASE && comb_ff == $past(comb_ff) + 2'd1))
      else $error("comb sequencing skipped a comb");

endmodule

@@ hdl/mcar_dpath.sv @@
// ----------------------------------------------------------------------------
// mcar_dpath
// Datapath of the reverb: configuration registers, per-comb state, the comb
// and allpass line memories, the arithmetic steps and the result register.
// ----------------------------------------------------------------------------
module mcar_dpath #(
   parameter int SAMPLE_RATE   = 48000,
   parameter int COMB_DEPTH    = 4096,
   parameter int ALLPASS_DEPTH = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mcar_pkg::cmd_type                   cmd,
   output mcar_pkg::status_type                status,
   input  logic signed [15:0]                  req_sample_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [15:0]                  rsp_sample_out,
   input  logic                                csr_write,
   input  logic [mcar_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mcar_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import mcar_pkg::*;

   // Line length clamped to 1..depth.
   function automatic int line_len(input int n, input int depth);
      if (n < 1) begin
         return 1;
      end else if (n > depth) begin
         return depth;
      end
      return n;
   endfunction

   localparam int CW    = $clog2(COMB_DEPTH);
   localparam int LW    = CW + 1;
   localparam int AW    = $clog2(ALLPASS_DEPTH);
   localparam int ALW   = AW + 1;
   localparam int CMA_W = $clog2(NUM_COMBS * COMB_DEPTH);
   localparam int AMA_W = $clog2(NUM_AP * ALLPASS_DEPTH);
   localparam int SC_W  = CW + 16;
   localparam int PR_W  = SC_W + 16;
   localparam int MAG_W = PR_W - 23;
   localparam int RP_W  = CW + 18;

   // Unclamped line lengths from the sample rate.
   localparam int COMB_RAW [NUM_COMBS] = '{
      SAMPLE_RATE * 297 / 10000, SAMPLE_RATE * 371 / 10000,
      SAMPLE_RATE * 411 / 10000, SAMPLE_RATE * 437 / 10000};
   localparam int AP_RAW [NUM_AP] = '{
      SAMPLE_RATE * 50 / 10000, SAMPLE_RATE * 17 / 10000,
      SAMPLE_RATE * 13 / 10000};

   // Per-sample LFO phase steps, rounded to nearest.
   localparam int LFO_DEN = 20 * SAMPLE_RATE;

   localparam int COMB_LEN [NUM_COMBS] = '{
      line_len(COMB_RAW[0], COMB_DEPTH), line_len(COMB_RAW[1], COMB_DEPTH),
      line_len(COMB_RAW[2], COMB_DEPTH), line_len(COMB_RAW[3], COMB_DEPTH)};
   localparam int COMB_SCALE [NUM_COMBS] = '{
      COMB_LEN[0] * MOD_K, COMB_LEN[1] * MOD_K,
      COMB_LEN[2] * MOD_K, COMB_LEN[3] * MOD_K};
   localparam int COMB_BASE [NUM_COMBS] = '{
      0, COMB_DEPTH, 2 * COMB_DEPTH, 3 * COMB_DEPTH};
   localparam int LFO_INC [NUM_COMBS] = '{
      (40 * 65536 + 10 * SAMPLE_RATE) / LFO_DEN,
      (54 * 65536 + 10 * SAMPLE_RATE) / LFO_DEN,
      (68 * 65536 + 10 * SAMPLE_RATE) / LFO_DEN,
      (82 * 65536 + 10 * SAMPLE_RATE) / LFO_DEN};
   localparam int AP_LEN [NUM_AP] = '{
      line_len(AP_RAW[0], ALLPASS_DEPTH), line_len(AP_RAW[1], ALLPASS_DEPTH),
      line_len(AP_RAW[2], ALLPASS_DEPTH)};
   localparam int AP_BASE [NUM_AP] = '{
      0, ALLPASS_DEPTH, 2 * ALLPASS_DEPTH};

   // Configuration registers.
   logic [14:0] fg_ff;
   logic [14:0] dg_ff;
   logic [15:0] wet_ff;

   // Per-comb and per-stage state.
   logic [15:0]        phase_ff  [NUM_COMBS];
   logic [CW-1:0]      wp_ff     [NUM_COMBS];
   logic               cfill_ff  [NUM_COMBS];
   logic signed [15:0] prev_ff   [NUM_COMBS];
   logic [AW-1:0]      ap_p_ff   [NUM_AP];
   logic               afill_ff  [NUM_AP];

   // Working registers.
   logic signed [15:0]    x_ff;
   logic signed [15:0]    sv_ff;
   logic [MAG_W-1:0]      mag_ff;
   logic [CW-1:0]         i1_ff;
   logic [CW-1:0]         i2_ff;
   logic [15:0]           fr_ff;
   logic signed [33:0]    acc_ff;
   logic signed [15:0]    y_ff;
   logic signed [16:0]    dp_ff;
   logic signed [15:0]    yd_ff;
   logic signed [17:0]    csum_ff;
   logic signed [15:0]    d_ff;
   logic signed [16:0]    t1_ff;
   logic signed [33:0]    m_ff;
   logic signed [15:0]    res_ff;
   logic                  rsp_valid_ff;
   logic signed [15:0]    rsp_data_ff;

   // Line memories.
   logic signed [15:0] comb_mem [NUM_COMBS * COMB_DEPTH];
   logic signed [15:0] ap_mem   [NUM_AP * ALLPASS_DEPTH];
   logic signed [15:0] comb_rdata_ff;
   logic               comb_rvalid_ff;
   logic signed [15:0] ap_rdata_ff;
   logic               ap_rvalid_ff;

   // Current comb and stage selections.
   logic [LW-1:0]      comb_len;
   logic [CW-1:0]      wp_cur;
   logic [AW-1:0]      ap_p;
   logic [ALW-1:0]     ap_len;
   logic [CW-1:0]      comb_ridx;
   logic [CMA_W-1:0]   comb_raddr;
   logic [CMA_W-1:0]   comb_waddr;
   logic [AMA_W-1:0]   ap_addr;
   logic               comb_re;
   logic               comb_we;
   logic               ap_we;
   logic signed [15:0] comb_wdata;
   logic signed [15:0] ap_wdata;
   logic signed [15:0] comb_rd;
   logic signed [15:0] ap_rd;

   assign comb_len   = LW'(COMB_LEN[cmd.comb]);
   assign wp_cur     = wp_ff[cmd.comb];
   assign ap_p       = ap_p_ff[cmd.stage];
   assign ap_len     = ALW'(AP_LEN[cmd.stage]);
   assign comb_ridx  = (cmd.op == OP_RD2) ? i2_ff : i1_ff;
   assign comb_raddr = CMA_W'(COMB_BASE[cmd.comb]) + CMA_W'(comb_ridx);
   assign comb_waddr = CMA_W'(COMB_BASE[cmd.comb]) + CMA_W'(wp_cur);
   assign ap_addr    = AMA_W'(AP_BASE[cmd.stage]) + AMA_W'(ap_p);
   assign comb_re    = (cmd.op == OP_RD1) || (cmd.op == OP_RD2);
   assign comb_we    = (cmd.op == OP_FBWR);
   assign ap_we      = (cmd.op == OP_APWR);

   // Entries never written read as zero.
   assign comb_rd = comb_rvalid_ff ? comb_rdata_ff : 16'sd0;
   assign ap_rd   = ap_rvalid_ff ? ap_rdata_ff : 16'sd0;

   // LFO step and sine lookup.
   logic [15:0] phase_in;
   assign phase_in = phase_ff[cmd.comb] + 16'(LFO_INC[cmd.comb]);

   // Modulation depth: |sine| times length times depth constant.
   logic [15:0]       abs_sv;
   logic [PR_W-1:0]   mag_prod;
   assign abs_sv   = sv_ff[15] ? 16'(-sv_ff) : 16'(sv_ff);
   assign mag_prod = PR_W'(abs_sv) * PR_W'(SC_W'(COMB_SCALE[cmd.comb]));

   // Read position in Q16, wrapped once around the line.
   logic signed [RP_W-1:0] wpos;
   logic signed [RP_W-1:0] smag;
   logic signed [RP_W-1:0] span;
   logic signed [RP_W-1:0] rp0;
   logic signed [RP_W-1:0] rp;
   logic [LW-1:0]          i1_inc;
   assign wpos = $signed({2'b00, wp_cur, 16'h0000});
   assign smag = $signed({{(RP_W - MAG_W){1'b0}}, mag_ff});
   assign span = $signed({1'b0, comb_len, 16'h0000});
   assign rp0  = sv_ff[15] ? (wpos + smag) : (wpos - smag);
   always_comb begin
      if (rp0 < 0) begin
         rp = rp0 + span;
      end else if (rp0 >= span) begin
         rp = rp0 - span;
      end else begin
         rp = rp0;
      end
   end
   assign i1_inc = LW'(rp[CW+15:16]) + LW'(1);

   // Linear interpolation products.
   logic signed [17:0] w_a;
   logic signed [33:0] prod_a;
   logic signed [33:0] prod_b;
   logic signed [34:0] isum;
   assign w_a    = $signed({1'b0, 17'h10000 - 17'(fr_ff)});
   assign prod_a = 34'(comb_rd) * 34'(w_a);
   assign prod_b = 34'(comb_rd) * 34'($signed({2'b00, fr_ff}));
   assign isum   = 35'(acc_ff) + 35'(prod_b);

   // One-pole damping.
   logic signed [16:0] ddiff;
   logic signed [32:0] dprod;
   logic signed [15:0] y2;
   assign ddiff = 17'(y_ff) - 17'(prev_ff[cmd.comb]);
   assign dprod = 33'(ddiff) * 33'(DAMP_K);
   assign y2    = sat16(SAT_W'(prev_ff[cmd.comb]) + SAT_W'(dp_ff));

   // Comb feedback write value.
   logic signed [31:0] fb_prod;
   assign fb_prod    = 32'(yd_ff) * 32'($signed({1'b0, fg_ff}));
   assign comb_wdata = sat16(SAT_W'(x_ff) + SAT_W'($signed(fb_prod[31:15])));

   // Allpass products.
   logic signed [15:0] dg_s;
   logic signed [31:0] ap_pd;
   logic signed [31:0] ap_pl;
   logic [ALW-1:0]     ap_p_inc;
   assign dg_s     = $signed({1'b0, dg_ff});
   assign ap_pd    = 32'(d_ff) * 32'(dg_s);
   assign ap_pl    = 32'(ap_rd) * 32'(dg_s);
   assign ap_wdata = sat16(SAT_W'(d_ff) + SAT_W'($signed(ap_pl[31:15])));
   assign ap_p_inc = ALW'(ap_p) + ALW'(1);

   // Dry/wet mix.
   logic [15:0]        mix_eff;
   logic signed [17:0] wet_s;
   logic signed [17:0] dry_s;
   logic signed [33:0] wet_prod;
   logic signed [34:0] mix_sum;
   assign mix_eff  = (wet_ff > WET_ONE) ? WET_ONE : wet_ff;
   assign wet_s    = $signed({2'b00, mix_eff});
   assign dry_s    = $signed({2'b00, WET_ONE - mix_eff});
   assign wet_prod = 34'(d_ff) * 34'(wet_s);
   assign mix_sum  = 35'(m_ff) + 35'(wet_prod);

   // Comb line memory.
   always_ff @(posedge clock) begin
      if (comb_we) begin
         comb_mem[comb_waddr] <= comb_wdata;
      end
      if (comb_re) begin
         comb_rdata_ff <= comb_mem[comb_raddr];
      end
   end

   // Allpass line memory.
   always_ff @(posedge clock) begin
      if (ap_we) begin
         ap_mem[ap_addr] <= ap_wdata;
      end
      if (cmd.op == OP_APRD) begin
         ap_rdata_ff <= ap_mem[ap_addr];
      end
   end

   // Configuration registers; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff  <= FEEDBACK_RESET;
         dg_ff  <= DIFFUSION_RESET;
         wet_ff <= WET_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FEEDBACK:  fg_ff  <= csr_wdata[14:0];
            CSR_DIFFUSION: dg_ff  <= csr_wdata[14:0];
            CSR_WET:       wet_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Persistent state of combs and allpass stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_COMBS; k++) begin
            phase_ff[k] <= 16'(k * 16384);
            wp_ff[k]    <= '0;
            cfill_ff[k] <= 1'b0;
            prev_ff[k]  <= 16'sd0;
         end
         for (int k = 0; k < NUM_AP; k++) begin
            ap_p_ff[k]  <= '0;
            afill_ff[k] <= 1'b0;
         end
         comb_rvalid_ff <= 1'b0;
         ap_rvalid_ff   <= 1'b0;
      end else begin
         if (cmd.op == OP_PHASE) begin
            phase_ff[cmd.comb] <= phase_in;
         end
         if (comb_re) begin
            comb_rvalid_ff <= cfill_ff[cmd.comb] || (comb_ridx < wp_cur);
         end
         if (cmd.op == OP_DAMP2) begin
            prev_ff[cmd.comb] <= y2;
         end
         if (cmd.op == OP_FBWR) begin
            if (LW'(wp_cur) + LW'(1) == comb_len) begin
               wp_ff[cmd.comb]    <= '0;
               cfill_ff[cmd.comb] <= 1'b1;
            end else begin
               wp_ff[cmd.comb] <= wp_cur + CW'(1);
            end
         end
         if (cmd.op == OP_APRD) begin
            ap_rvalid_ff <= afill_ff[cmd.stage];
         end
         if (cmd.op == OP_APWR) begin
            if (ap_p_inc == ap_len) begin
               ap_p_ff[cmd.stage]  <= '0;
               afill_ff[cmd.stage] <= 1'b1;
            end else begin
               ap_p_ff[cmd.stage] <= AW'(ap_p_inc);
            end
         end
      end
   end

   // Arithmetic steps.
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            x_ff    <= req_sample_in;
            csum_ff <= 18'sd0;
         end
         OP_PHASE: sv_ff  <= SINE_TAB[phase_in[15 -: SINE_BITS]];
         OP_MAG:   mag_ff <= mag_prod[PR_W-1:23];
         OP_RPOS: begin
            i1_ff <= rp[CW+15:16];
            fr_ff <= rp[15:0];
            i2_ff <= (i1_inc == comb_len) ? '0 : CW'(i1_inc);
         end
         OP_RD2:    acc_ff <= prod_a;
         OP_INTERP: y_ff   <= sat16(SAT_W'($signed(isum[34:16])));
         OP_DAMP1:  dp_ff  <= $signed(dprod[31:15]);
         OP_DAMP2: begin
            yd_ff   <= y2;
            csum_ff <= csum_ff + 18'(y2);
         end
         OP_SUM:   d_ff  <= sat16(SAT_W'(csum_ff >>> 2));
         OP_APMUL: t1_ff <= $signed(ap_pd[31:15]);
         OP_APWR:  d_ff  <= sat16(SAT_W'(ap_rd) - SAT_W'(t1_ff));
         OP_MIX1:  m_ff  <= 34'(x_ff) * 34'(dry_s);
         OP_MIX2:  res_ff <= sat16(SAT_W'($signed(mix_sum[34:15])));
         default: ;
      endcase
   end

   // Result register toward the response channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_OUT) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.op == OP_OUT) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample_out  = rsp_data_ff;
   assign status.out_busy = rsp_valid_ff && rsp_stall;

   // Comb reads stay inside the current line.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_RD1 || cmd.op == OP_RD2) |-> (LW'(comb_ridx) < comb_len))
      else $error("comb read index beyond line length");

   // Allpass reads stay inside the current line.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_APRD) |-> (ALW'(ap_p) < ap_len))
      else $error("allpass position beyond line length");

   // A new result never overwrites one that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_OUT) |-> !(rsp_valid_ff && rsp_stall))
      else $error("pending response overwritten");

endmodule

@@ dv/modulated_comb_allpass_reverb_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modulated_comb_allpass_reverb_test
// Self-checking testbench for the modulated comb and allpass reverb. A
// directed table of samples is followed by random audio under several gain
// settings. Every request is run through a local sample-exact model of the
// reverb, and each response is compared with the oldest expected sample.
// ----------------------------------------------------------------------------
module modulated_comb_allpass_reverb_test;
   import mcar_pkg::*;

   localparam int SAMPLE_RATE   = 48000;
   localparam int COMB_DEPTH    = 4096;
   localparam int ALLPASS_DEPTH = 256;
   localparam int TAB_SIZE      = 256;
   localparam int SETTLE_CYCLES = 70;
   localparam int PHASE_ITEMS   = 170;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic signed [15:0]    req_sample_in = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic signed [15:0]    rsp_sample_out;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int  error_count = 0;
   bit  steady = 1'b0;
   logic signed [15:0] pending_samples[$];

   // Local copy of the reverb state and its settings.
   logic signed [15:0] comb_mem [NUM_COMBS][COMB_DEPTH];
   int                 comb_wr  [NUM_COMBS];
   longint             lowpass_prev [NUM_COMBS];
   logic [15:0]        lfo_acc  [NUM_COMBS];
   logic signed [15:0] ap_mem   [NUM_AP][ALLPASS_DEPTH];
   int                 ap_rd    [NUM_AP];
   logic signed [15:0] sine_lut [TAB_SIZE];
   int                 comb_len [NUM_COMBS];
   int                 ap_len   [NUM_AP];
   int                 lfo_step [NUM_COMBS];
   longint             fb_gain;
   longint             diff_gain;
   longint             wet_gain;

   modulated_comb_allpass_reverb DUT (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Clamp a wide value to signed 16 bits.
   function automatic logic signed [15:0] clip16(input longint v);
      if (v > 32767) begin
         return 16'sh7FFF;
      end else if (v < -32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   // One sine table entry from the quarter-wave odd polynomial in Q30.
   function automatic logic signed [15:0] sine_q15(input int k);
      logic [63:0] t, q, u, u2, p, s, v;
      t = 64'(k) * 4;
      q = (t / TAB_SIZE) & 3;
      u = ((t % TAB_SIZE) << 30) / TAB_SIZE;
      if (q[0]) begin
         u = (64'd1 << 30) - u;
      end
      u2 = (u * u) >> 30;
      p = 64'd5026996 - ((u2 * 64'd172272) >> 30);
      p = 64'd85569305 - ((u2 * p) >> 30);
      p = 64'd693598668 - ((u2 * p) >> 30);
      p = 64'd1686629713 - ((u2 * p) >> 30);
      s = (u * p) >> 30;
      v = (s * 32767 + (64'd1 << 29)) >> 30;
      if (v > 32767) begin
         v = 32767;
      end
      return q[1] ? -$signed(v[15:0]) : $signed(v[15:0]);
   endfunction

   function automatic int clamp_len(input int mult, input int depth);
      int n;
      n = SAMPLE_RATE * mult / 10000;
      return n < 1 ? 1 : (n > depth ? depth : n);
   endfunction

   // Bring the local model to its power-on state.
   task automatic reverb_reset();
      int cm[NUM_COMBS] = '{297, 371, 411, 437};
      int am[NUM_AP] = '{50, 17, 13};
      longint num, den;
      for (int i = 0; i < NUM_COMBS; i++) begin
         comb_len[i] = clamp_len(cm[i], COMB_DEPTH);
         num = longint'(20 + 7 * i) * 65536;
         den = longint'(10) * SAMPLE_RATE;
         lfo_step[i] = int'((2 * num + den) / (2 * den));
         comb_wr[i] = 0;
         lowpass_prev[i] = 0;
         lfo_acc[i] = 16'(i * 16'h4000);
         for (int k = 0; k < COMB_DEPTH; k++) comb_mem[i][k] = '0;
      end
      for (int i = 0; i < NUM_AP; i++) begin
         ap_len[i] = clamp_len(am[i], ALLPASS_DEPTH);
         ap_rd[i] = 0;
         for (int k = 0; k < ALLPASS_DEPTH; k++) ap_mem[i][k] = '0;
      end
      for (int k = 0; k < TAB_SIZE; k++) sine_lut[k] = sine_q15(k);
      fb_gain = FEEDBACK_RESET;
      diff_gain = DIFFUSION_RESET;
      wet_gain = WET_RESET;
   endtask

   // Reverberate one sample and advance the model state.
   function automatic logic signed [15:0] reverb_sample(input logic signed [15:0] dry);
      longint x, acc, d, y, mag, rpos, span, a, b, frac, dl, o, mix;
      int len, wp, i1, i2, p;
      logic signed [15:0] sv;
      x = dry;
      acc = 0;
      for (int i = 0; i < NUM_COMBS; i++) begin
         len = comb_len[i];
         wp = comb_wr[i] >= len ? 0 : comb_wr[i];
         span = longint'(len) << 16;
         lfo_acc[i] = lfo_acc[i] + 16'(lfo_step[i]);
         sv = sine_lut[lfo_acc[i] * TAB_SIZE >> 16];
         mag = ((sv < 0 ? -longint'(sv) : longint'(sv)) * len * MOD_K) >> 23;
         rpos = (longint'(wp) << 16) - (sv < 0 ? -mag : mag);
         if (rpos < 0) begin
            rpos += span;
         end else if (rpos >= span) begin
            rpos -= span;
         end
         i1 = int'(rpos >> 16);
         if (i1 >= len) i1 = 0;
         frac = rpos & 64'hFFFF;
         i2 = i1 + 1 >= len ? 0 : i1 + 1;
         a = comb_mem[i][i1];
         b = comb_mem[i][i2];
         y = clip16((a * (65536 - frac) + b * frac) >>> 16);
         y = clip16(lowpass_prev[i] + (((y - lowpass_prev[i]) * DAMP_K) >>> 15));
         lowpass_prev[i] = y;
         comb_mem[i][wp] = clip16(x + ((y * fb_gain) >>> 15));
         comb_wr[i] = wp + 1 >= len ? 0 : wp + 1;
         acc += y;
      end
      // Allpass cascade on the averaged comb sum.
      d = clip16(acc >>> 2);
      for (int i = 0; i < NUM_AP; i++) begin
         p = ap_rd[i] >= ap_len[i] ? 0 : ap_rd[i];
         dl = ap_mem[i][p];
         o = clip16(dl - ((d * diff_gain) >>> 15));
         ap_mem[i][p] = clip16(d + ((dl * diff_gain) >>> 15));
         ap_rd[i] = p + 1 >= ap_len[i] ? 0 : p + 1;
         d = o;
      end
      mix = wet_gain > 32768 ? 32768 : wet_gain;
      return clip16((x * (32768 - mix) + d * mix) >>> 15);
   endfunction

   // Write one register and mirror it in the model.
   task automatic csr_put(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_FEEDBACK:  fb_gain = val & 16'h7FFF;
         CSR_DIFFUSION: diff_gain = val & 16'h7FFF;
         CSR_WET:       wet_gain = val;
         default: ;
      endcase
   endtask

   // Present one request and hold it until taken; predict on acceptance.
   task automatic send_request(input logic signed [15:0] s, input bit known,
                               input logic signed [15:0] typed);
      logic signed [15:0] predicted;
      while (!steady && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_in <= s;
      do @(posedge clock); while (req_stall);
      predicted = reverb_sample(s);
      pending_samples.push_back(known ? typed : predicted);
   endtask

   // Stop sending and let every outstanding response drain.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [15:0] random_sample();
      case ($urandom_range(9))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'($signed($urandom_range(1023)) - 512);
         3: return '0;
         default: return 16'($urandom);
      endcase
   endfunction

   // Check responses against the oldest expected sample; stall at random.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_samples.size() == 0) begin
               $error("unexpected response sample_out=%0d", rsp_sample_out);
               error_count++;
            end else if (rsp_sample_out !== pending_samples[0]) begin
               $error("sample_out mismatch: expected %0d, actual %0d",
                      pending_samples[0], rsp_sample_out);
               error_count++;
               void'(pending_samples.pop_front());
            end else begin
               void'(pending_samples.pop_front());
            end
         end
         rsp_stall <= !steady && $urandom_range(99) < 11;
      end
   end

   typedef struct {
      logic signed [15:0] smp;
      bit                 known;
      logic signed [15:0] res;
   } directed_row_type;

   // First row sees empty lines, so only the dry share reaches the output.
   directed_row_type directed_rows [] = '{
      '{16'sh7FFF, 1'b1, 16'sd22937}, '{16'sh8000, 1'b0, 0}, '{16'sh0000, 1'b0, 0},
      '{16'sh0001, 1'b0, 0}, '{16'shFFFF, 1'b0, 0}, '{16'sh5555, 1'b0, 0},
      '{16'shAAAA, 1'b0, 0}, '{16'sh7FFF, 1'b0, 0}, '{16'sh7FFF, 1'b0, 0},
      '{16'sh7FFF, 1'b0, 0}, '{16'sh7FFF, 1'b0, 0}, '{16'sh8000, 1'b0, 0},
      '{16'sh8000, 1'b0, 0}, '{16'sh8000, 1'b0, 0}, '{16'sh8000, 1'b0, 0},
      '{16'sh0000, 1'b0, 0}, '{16'sh0000, 1'b0, 0}, '{16'sh1234, 1'b0, 0},
      '{16'shEDCB, 1'b0, 0}, '{16'sh4000, 1'b0, 0}
   };

   // Gain settings per phase; the last column is the wet share as written.
   logic [15:0] phase_gains [][3] = '{
      '{16'hFFFF, 16'hFFFF, 16'hFFFF}, '{16'h0000, 16'h0000, 16'h0000},
      '{16'h7FFF, 16'h7FFF, 16'h8000}, '{16'd26214, 16'd16384, 16'd40000},
      '{16'd100, 16'd30000, 16'd20000}, '{16'hFFFF, 16'h0001, 16'd32769},
      '{16'd20000, 16'd8000, 16'd9830}
   };

   initial begin
      reverb_reset();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[r]) begin
         send_request(directed_rows[r].smp, directed_rows[r].known, directed_rows[r].res);
      end
      foreach (phase_gains[ph]) begin
         drain();
         csr_put(CSR_FEEDBACK, phase_gains[ph][0]);
         csr_put(CSR_DIFFUSION, phase_gains[ph][1]);
         csr_put(CSR_WET, phase_gains[ph][2]);
         // A write to the unused index must change nothing.
         csr_put(CSR_UNUSED, 16'(16'h7FFF & $urandom));
         steady = (ph == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_request(random_sample(), 1'b0, '0);
         end
         steady = 1'b0;
      end
      drain();
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

endmodule

@@ files.f @@
hdl/mcar_pkg.sv
hdl/mcar_ctrl.sv
hdl/mcar_dpath.sv
hdl/modulated_comb_allpass_reverb.sv
dv/modulated_comb_allpass_reverb_test.sv
